FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants of the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int NUM_REGS = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_POINT_X  = 3'd0;
    localparam logic [2:0] REG_POINT_Y  = 3'd1;
    localparam logic [2:0] REG_POINT_Z  = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_EMIT1 = 4'b0100,
        ST_EMIT2 = 4'b1000
    } back_state_t;

endpackage

FILE: rtl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// Accepts triangles and computes the three signed plane distances.
// ----------------------------------------------------------------------------
module tpc_front #(
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic [8:0][COORD_BITS-1:0]          vtx_in,
    input  logic [31:0]                         colour_in,
    input  logic [5:0][COORD_BITS-1:0]          plane,
    output logic                                push,
    output logic [8:0][COORD_BITS-1:0]          vtx,
    output logic [31:0]                         colour,
    output logic [2:0][2*COORD_BITS+2:0]        vdist,
    output logic [1:0]                          inflight
);
    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 1;
    localparam int DB = 2 * C + 3;

    logic                   s1_valid_reg;
    logic [8:0][C-1:0]      s1_vtx_reg;
    logic [31:0]            s1_col_reg;
    logic                   s2_valid_reg;
    logic [8:0][C-1:0]      s2_vtx_reg;
    logic [31:0]            s2_col_reg;
    logic signed [PW-1:0]   s2_prod_reg [9];
    logic signed [PW-1:0]   prod_next [9];
    logic signed [C:0]      rel [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            rel[k] = $signed({s1_vtx_reg[k][C-1], s1_vtx_reg[k]})
                   - $signed({plane[k%3][C-1], plane[k%3]});
            prod_next[k] = $signed(plane[3 + k%3]) * rel[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_vtx_reg <= vtx_in;
            s1_col_reg <= colour_in;
        end
        if (s1_valid_reg)
        begin
            s2_vtx_reg <= s1_vtx_reg;
            s2_col_reg <= s1_col_reg;
            for (int k = 0; k < 9; k++)
            begin
                s2_prod_reg[k] <= prod_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vdist[k] = DB'(s2_prod_reg[3*k]) + DB'(s2_prod_reg[3*k+1])
                     + DB'(s2_prod_reg[3*k+2]);
        end
    end

    assign push     = s2_valid_reg;
    assign vtx      = s2_vtx_reg;
    assign colour   = s2_col_reg;
    assign inflight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

FILE: rtl/tpc_queue.sv
// ----------------------------------------------------------------------------
// tpc_queue
// Small FIFO between the distance front end and the clipping back end.
// ----------------------------------------------------------------------------
module tpc_queue #(
    parameter int W = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  logic [W-1:0]                                wdata,
    input  logic                                        pop,
    output logic [W-1:0]                                rdata,
    output logic                                        empty,
    output logic [$clog2(tpc_pkg::QUEUE_DEPTH+1)-1:0]   count
);
    import tpc_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

FILE: rtl/tpc_lerp.sv
// ----------------------------------------------------------------------------
// tpc_lerp
// Bit-serial multiply-divide for one axis: a + s*floor(|b-a|*da/den).
// ----------------------------------------------------------------------------
module tpc_lerp #(
    parameter int COORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        step,
    input  logic [COORD_BITS-1:0]       a_in,
    input  logic [COORD_BITS-1:0]       b_in,
    input  logic [2*COORD_BITS+2:0]     da_in,
    input  logic [2*COORD_BITS+2:0]     den_in,
    output logic [COORD_BITS-1:0]       x
);
    localparam int C  = COORD_BITS;
    localparam int DB = 2 * C + 3;
    localparam int RW = DB + 2;

    logic [C-1:0]       a_reg;
    logic               neg_reg;
    logic [C:0]         mag_reg;
    logic [C:0]         q_reg;
    logic [DB-1:0]      r_reg;
    logic [DB-1:0]      da_reg;
    logic [DB-1:0]      den_reg;

    logic signed [C:0]  diff;
    logic [C:0]         mag;
    logic [RW-1:0]      r2;
    logic [RW-1:0]      den1;
    logic [RW-1:0]      den2;
    logic [RW-1:0]      r_next;
    logic [C:0]         q_next;
    logic [C:0]         a_ext;

    assign diff = $signed({b_in[C-1], b_in}) - $signed({a_in[C-1], a_in});
    assign mag  = diff[C] ? (C+1)'(-diff) : diff;

    always_comb
    begin
        den1 = RW'(den_reg);
        den2 = {den1[RW-2:0], 1'b0};
        r2   = {1'b0, r_reg, 1'b0} + (mag_reg[C] ? RW'(da_reg) : '0);
        if (r2 >= den2)
        begin
            r_next = r2 - den2;
            q_next = {q_reg[C-1:0], 1'b0} + (C+1)'(2);
        end
        else if (r2 >= den1)
        begin
            r_next = r2 - den1;
            q_next = {q_reg[C-1:0], 1'b0} + (C+1)'(1);
        end
        else
        begin
            r_next = r2;
            q_next = {q_reg[C-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg   <= a_in;
            neg_reg <= diff[C];
            mag_reg <= mag;
            q_reg   <= '0;
            r_reg   <= '0;
            da_reg  <= da_in;
            den_reg <= den_in;
        end
        else if (step)
        begin
            mag_reg <= {mag_reg[C-1:0], 1'b0};
            q_reg   <= q_next;
            r_reg   <= r_next[DB-1:0];
        end
    end

    assign a_ext = {a_reg[C-1], a_reg};
    assign x = neg_reg ? C'(a_ext - q_reg) : C'(a_ext + q_reg);

endmodule

FILE: rtl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// Classifies queued triangles and emits zero, one or two clipped triangles.
// ----------------------------------------------------------------------------
module tpc_back #(
    parameter int COORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  logic [8:0][COORD_BITS-1:0]      q_vtx,
    input  logic [31:0]                     q_colour,
    input  logic [2:0][2*COORD_BITS+2:0]    q_dist,
    output logic                            pop,
    output logic                            res_valid,
    output logic [8:0][COORD_BITS-1:0]      res_vtx,
    output logic [31:0]                     res_colour,
    output logic                            res_last
);
    import tpc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DB = 2 * C + 3;
    localparam int NW = $clog2(C + 2);

    back_state_t        st_reg;
    back_state_t        st_next;
    logic [NW-1:0]      cnt_reg;
    logic               two_reg;
    logic [2:0][C-1:0]  va_reg;
    logic [2:0][C-1:0]  vb_reg;
    logic [31:0]        col_reg;
    logic               valid_reg;
    logic [8:0][C-1:0]  vtx_reg;
    logic [31:0]        rcol_reg;
    logic               last_reg;

    logic [2:0]         in_mask;
    logic [1:0]         pa0, pb0, pa1, pb1;
    logic [2:0][C-1:0]  vert [3];
    logic               load;
    logic               step;
    logic [DB-1:0]      da [2];
    logic [DB-1:0]      den [2];
    logic [C-1:0]       xa [2][3];
    logic [C-1:0]       xb [2][3];
    logic [C-1:0]       xo [2][3];

    assign in_mask = {~q_dist[2][DB-1], ~q_dist[1][DB-1], ~q_dist[0][DB-1]};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vert[k][i] = q_vtx[3*k+i];
            end
        end
    end

    always_comb
    begin
        case (in_mask)
            3'b001:  begin pa0 = 2'd0; pb0 = 2'd1; pa1 = 2'd0; pb1 = 2'd2; end
            3'b010:  begin pa0 = 2'd1; pb0 = 2'd0; pa1 = 2'd1; pb1 = 2'd2; end
            3'b100:  begin pa0 = 2'd2; pb0 = 2'd0; pa1 = 2'd2; pb1 = 2'd1; end
            3'b011:  begin pa0 = 2'd0; pb0 = 2'd2; pa1 = 2'd1; pb1 = 2'd2; end
            3'b101:  begin pa0 = 2'd0; pb0 = 2'd1; pa1 = 2'd2; pb1 = 2'd1; end
            3'b110:  begin pa0 = 2'd1; pb0 = 2'd0; pa1 = 2'd2; pb1 = 2'd0; end
            default: begin pa0 = 2'd0; pb0 = 2'd0; pa1 = 2'd0; pb1 = 2'd0; end
        endcase
    end

    always_comb
    begin
        da[0]  = q_dist[pa0];
        da[1]  = q_dist[pa1];
        den[0] = q_dist[pa0] - q_dist[pb0];
        den[1] = q_dist[pa1] - q_dist[pb1];
        for (int i = 0; i < 3; i++)
        begin
            xa[0][i] = vert[pa0][i];
            xb[0][i] = vert[pb0][i];
            xa[1][i] = vert[pa1][i];
            xb[1][i] = vert[pb1][i];
        end
    end

    assign pop  = (st_reg == ST_IDLE) && !q_empty;
    assign load = pop && (in_mask != 3'b000) && (in_mask != 3'b111);
    assign step = (st_reg == ST_CALC);

    for (genvar p = 0; p < 2; p++)
    begin : g_pair
        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            tpc_lerp #(
                .COORD_BITS (C)
            ) u_lerp (
                .clk    (clk),
                .load   (load),
                .step   (step),
                .a_in   (xa[p][i]),
                .b_in   (xb[p][i]),
                .da_in  (da[p]),
                .den_in (den[p]),
                .x      (xo[p][i])
            );
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  st_next = load ? ST_CALC : ST_IDLE;
            ST_CALC:  st_next = (cnt_reg == NW'(C)) ? ST_EMIT1 : ST_CALC;
            ST_EMIT1: st_next = two_reg ? ST_EMIT2 : ST_IDLE;
            ST_EMIT2: st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_reg   <= (st_reg == ST_CALC) ? cnt_reg + 1'b1 : '0;
            valid_reg <= (pop && in_mask == 3'b111) || (st_reg == ST_EMIT1)
                       || (st_reg == ST_EMIT2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            two_reg <= (in_mask == 3'b011) || (in_mask == 3'b101) || (in_mask == 3'b110);
            va_reg  <= vert[pa0];
            vb_reg  <= vert[pa1];
            col_reg <= q_colour;
        end
        case (st_reg)
            ST_IDLE:
            begin
                vtx_reg  <= q_vtx;
                rcol_reg <= q_colour;
                last_reg <= 1'b1;
            end
            ST_EMIT1:
            begin
                rcol_reg <= col_reg;
                last_reg <= !two_reg;
                for (int i = 0; i < 3; i++)
                begin
                    vtx_reg[i]   <= va_reg[i];
                    vtx_reg[3+i] <= two_reg ? vb_reg[i] : xo[0][i];
                    vtx_reg[6+i] <= two_reg ? xo[0][i] : xo[1][i];
                end
            end
            ST_EMIT2:
            begin
                rcol_reg <= col_reg;
                last_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    vtx_reg[i]   <= vb_reg[i];
                    vtx_reg[3+i] <= xo[0][i];
                    vtx_reg[6+i] <= xo[1][i];
                end
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign res_valid  = valid_reg;
    assign res_vtx    = vtx_reg;
    assign res_colour = rcol_reg;
    assign res_last   = last_reg;

endmodule

FILE: rtl/triangle_plane_clipper_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_unit
// Clips one triangle per transfer against a plane set over an APB-style port.
// ----------------------------------------------------------------------------
// Usage: drive a triangle on in_ax..in_cz and in_colour with start high; it is
// taken at a clock edge where busy is low. The front end computes the three
// plane distances in two pipeline stages and pushes the item into a
// four-entry queue; busy rises when queued plus in-flight items reach its depth.
// The back end pops one item at a time. An all-inside triangle leaves in the
// cycle after the pop, one per cycle while the queue holds items.
// A clipped triangle first runs its full division in the bit-serial
// multiply-divide units (six, one per axis of each intersection), then puts
// out one or two results on consecutive cycles. An all-outside triangle
// gives no result. result_valid marks each result for one cycle; last_of_run
// flags the final one of an item. The receiver cannot stall. Reset empties
// the pipeline and queue and loads the default plane (z = 0.1, normal +z).
// ----------------------------------------------------------------------------
module triangle_plane_clipper_unit #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0]      paddr,
    input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]    pwdata,
    output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]    prdata,
    output logic                                        pready,
    input  logic                                        start,
    output logic                                        busy,
    input  logic signed [COORD_BITS-1:0]                in_ax,
    input  logic signed [COORD_BITS-1:0]                in_ay,
    input  logic signed [COORD_BITS-1:0]                in_az,
    input  logic signed [COORD_BITS-1:0]                in_bx,
    input  logic signed [COORD_BITS-1:0]                in_by,
    input  logic signed [COORD_BITS-1:0]                in_bz,
    input  logic signed [COORD_BITS-1:0]                in_cx,
    input  logic signed [COORD_BITS-1:0]                in_cy,
    input  logic signed [COORD_BITS-1:0]                in_cz,
    input  logic [31:0]                                 in_colour,
    output logic                                        result_valid,
    output logic signed [COORD_BITS-1:0]                out_ax,
    output logic signed [COORD_BITS-1:0]                out_ay,
    output logic signed [COORD_BITS-1:0]                out_az,
    output logic signed [COORD_BITS-1:0]                out_bx,
    output logic signed [COORD_BITS-1:0]                out_by,
    output logic signed [COORD_BITS-1:0]                out_bz,
    output logic signed [COORD_BITS-1:0]                out_cx,
    output logic signed [COORD_BITS-1:0]                out_cy,
    output logic signed [COORD_BITS-1:0]                out_cz,
    output logic [31:0]                                 out_colour,
    output logic                                        last_of_run
);
    import tpc_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int DB     = 2 * C + 3;
    localparam int DW     = (C > 32) ? 64 : 32;
    localparam int AW     = (C > 32) ? 6 : 5;
    localparam int ASH    = AW - 3;
    localparam int QW     = 9 * C + 32 + 3 * DB;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int RST_PZ = ((2 ** FRAC_BITS) + 5) / 10;
    localparam int RST_NZ = 2 ** FRAC_BITS;

    logic [5:0][C-1:0]      plane_reg;
    logic [2:0]             reg_idx;
    logic                   take;
    logic [8:0][C-1:0]      vtx_in;
    logic                   f_push;
    logic [8:0][C-1:0]      f_vtx;
    logic [31:0]            f_colour;
    logic [2:0][DB-1:0]     f_dist;
    logic [1:0]             f_inflight;
    logic [QW-1:0]          q_wdata;
    logic [QW-1:0]          q_rdata;
    logic                   q_empty;
    logic [CW-1:0]          q_count;
    logic                   q_pop;
    logic [8:0][C-1:0]      r_vtx;

    assign reg_idx = paddr[AW-1:ASH];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg[REG_POINT_X]  <= '0;
            plane_reg[REG_POINT_Y]  <= '0;
            plane_reg[REG_POINT_Z]  <= C'(RST_PZ);
            plane_reg[REG_NORMAL_X] <= '0;
            plane_reg[REG_NORMAL_Y] <= '0;
            plane_reg[REG_NORMAL_Z] <= C'(RST_NZ);
        end
        else if (psel && penable && pwrite && pready && (reg_idx <= REG_NORMAL_Z))
        begin
            plane_reg[reg_idx] <= pwdata[C-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx <= REG_NORMAL_Z)
        begin
            prdata = DW'($signed(plane_reg[reg_idx]));
        end
    end

    assign busy = ({1'b0, q_count} + (CW+1)'(f_inflight)) >= (CW+1)'(QUEUE_DEPTH);
    assign take = start && !busy;
    assign vtx_in = {in_cz, in_cy, in_cx, in_bz, in_by, in_bx, in_az, in_ay, in_ax};

    tpc_front #(
        .COORD_BITS (C)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .vtx_in    (vtx_in),
        .colour_in (in_colour),
        .plane     (plane_reg),
        .push      (f_push),
        .vtx       (f_vtx),
        .colour    (f_colour),
        .vdist     (f_dist),
        .inflight  (f_inflight)
    );

    assign q_wdata = {f_colour, f_vtx, f_dist};

    tpc_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    tpc_back #(
        .COORD_BITS (C)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_vtx      (q_rdata[3*DB +: 9*C]),
        .q_colour   (q_rdata[3*DB + 9*C +: 32]),
        .q_dist     (q_rdata[0 +: 3*DB]),
        .pop        (q_pop),
        .res_valid  (result_valid),
        .res_vtx    (r_vtx),
        .res_colour (out_colour),
        .res_last   (last_of_run)
    );

    assign out_ax = r_vtx[0];
    assign out_ay = r_vtx[1];
    assign out_az = r_vtx[2];
    assign out_bx = r_vtx[3];
    assign out_by = r_vtx[4];
    assign out_bz = r_vtx[5];
    assign out_cx = r_vtx[6];
    assign out_cy = r_vtx[7];
    assign out_cz = r_vtx[8];

endmodule

FILE: test/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// Watches the register port and both transfer channels of the triangle plane
// clipper, predicts the clipped triangles of every accepted input and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tpc_checker
    import tpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               start,
    input  logic               busy,
    input  logic [9:0][31:0]   tri_in,
    input  logic               result_valid,
    input  logic [9:0][31:0]   tri_out,
    input  logic               last_of_run,
    output int                 errors,
    output int                 pending
);

    localparam int CLIP_SLOTS = 32;

    typedef struct packed {
        logic [9:0][31:0] w;
        logic             last;
    } clipped_t;

    typedef logic signed [127:0] wide_t;

    logic [31:0] plane [NUM_REGS];
    clipped_t    clip_mem [CLIP_SLOTS];
    int          wr_ptr = 0;
    int          rd_ptr = 0;

    assign pending = wr_ptr - rd_ptr;

    function automatic wide_t plane_dist(logic [9:0][31:0] t, int k);
        wide_t d;
        wide_t n;
        wide_t rel;
        d = 0;
        for (int i = 0; i < 3; i++)
        begin
            n   = wide_t'(signed'(plane[REG_NORMAL_X + i]));
            rel = wide_t'(signed'(t[3*k+i])) - wide_t'(signed'(plane[REG_POINT_X + i]));
            d   = d + n * rel;
        end
        return d;
    endfunction

    // point between inside vertex a and outside vertex b, truncated toward a
    function automatic logic [2:0][31:0] cross_point(logic [9:0][31:0] t, int a, int b,
                                                     wide_t da, wide_t db);
        logic [2:0][31:0] x;
        wide_t diff;
        logic [127:0] mag;
        logic [127:0] q;
        for (int i = 0; i < 3; i++)
        begin
            diff = wide_t'(signed'(t[3*b+i])) - wide_t'(signed'(t[3*a+i]));
            mag  = diff < 0 ? -diff : diff;
            q    = (mag * 128'(da)) / 128'(da - db);
            x[i] = diff < 0 ? t[3*a+i] - q[31:0] : t[3*a+i] + q[31:0];
        end
        return x;
    endfunction

    task automatic store_clip(clipped_t r);
        clip_mem[wr_ptr % CLIP_SLOTS] = r;
        wr_ptr++;
    endtask

    task automatic predict_clip(logic [9:0][31:0] t);
        wide_t d [3];
        int ins [3];
        int outs [3];
        int ni;
        int no;
        clipped_t r;
        logic [2:0][31:0] x1;
        logic [2:0][31:0] x2;
        ni = 0;
        no = 0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = plane_dist(t, k);
            if (d[k] >= 0)
            begin
                ins[ni] = k;
                ni++;
            end
            else
            begin
                outs[no] = k;
                no++;
            end
        end
        r.w[9] = t[9];
        r.last = 1'b1;
        if (ni == 3)
        begin
            r.w = t;
            store_clip(r);
        end
        else if (ni == 1)
        begin
            x1 = cross_point(t, ins[0], outs[0], d[ins[0]], d[outs[0]]);
            x2 = cross_point(t, ins[0], outs[1], d[ins[0]], d[outs[1]]);
            r.w[2:0] = t[3*ins[0] +: 3];
            r.w[5:3] = x1;
            r.w[8:6] = x2;
            store_clip(r);
        end
        else if (ni == 2)
        begin
            x1 = cross_point(t, ins[0], outs[0], d[ins[0]], d[outs[0]]);
            x2 = cross_point(t, ins[1], outs[0], d[ins[1]], d[outs[0]]);
            r.w[2:0] = t[3*ins[0] +: 3];
            r.w[5:3] = t[3*ins[1] +: 3];
            r.w[8:6] = x1;
            r.last   = 1'b0;
            store_clip(r);
            r.w[2:0] = t[3*ins[1] +: 3];
            r.w[5:3] = x1;
            r.w[8:6] = x2;
            r.last   = 1'b1;
            store_clip(r);
        end
    endtask

    task automatic mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (errors < 10)
            $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clipped_t e;
        if (!rst_n)
        begin
            plane[REG_POINT_X]  <= 32'd0;
            plane[REG_POINT_Y]  <= 32'd0;
            plane[REG_POINT_Z]  <= 32'd6554;
            plane[REG_NORMAL_X] <= 32'd0;
            plane[REG_NORMAL_Y] <= 32'd0;
            plane[REG_NORMAL_Z] <= 32'd65536;
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[4:2] < NUM_REGS)
                plane[paddr[4:2]] <= pwdata;
            if (start && !busy)
                predict_clip(tri_in);
            if (result_valid)
            begin
                if (wr_ptr == rd_ptr)
                    mismatch("unexpected result", 32'd0, tri_out[0]);
                else
                begin
                    e = clip_mem[rd_ptr % CLIP_SLOTS];
                    rd_ptr++;
                    for (int i = 0; i < 10; i++)
                        if (e.w[i] !== tri_out[i])
                            mismatch($sformatf("field %0d", i), e.w[i], tri_out[i]);
                    if (e.last !== last_of_run)
                        mismatch("last_of_run", 32'(e.last), 32'(last_of_run));
                end
            end
        end
    end

endmodule

FILE: test/tb_triangle_plane_clipper_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_plane_clipper_unit
// Drives triangles and plane settings into the clipper with random gaps,
// runs directed cases on the default plane and then random triangles on a
// series of planes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_triangle_plane_clipper_unit;
    import tpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [4:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             start = 1'b0;
    logic             busy;
    logic [9:0][31:0] tri_in = '0;
    logic             result_valid;
    logic [9:0][31:0] tri_out;
    logic             last_of_run;
    int               errors;
    int               pending;
    int               idle_cycles = 0;

    always #6 clk = ~clk;

    triangle_plane_clipper_unit uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .in_ax(tri_in[0]), .in_ay(tri_in[1]), .in_az(tri_in[2]),
        .in_bx(tri_in[3]), .in_by(tri_in[4]), .in_bz(tri_in[5]),
        .in_cx(tri_in[6]), .in_cy(tri_in[7]), .in_cz(tri_in[8]),
        .in_colour(tri_in[9]),
        .result_valid(result_valid),
        .out_ax(tri_out[0]), .out_ay(tri_out[1]), .out_az(tri_out[2]),
        .out_bx(tri_out[3]), .out_by(tri_out[4]), .out_bz(tri_out[5]),
        .out_cx(tri_out[6]), .out_cy(tri_out[7]), .out_cz(tri_out[8]),
        .out_colour(tri_out[9]),
        .last_of_run(last_of_run)
    );

    tpc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .start(start), .busy(busy), .tri_in(tri_in),
        .result_valid(result_valid), .tri_out(tri_out), .last_of_run(last_of_run),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // transfer one triangle; start stays high when the next one follows at once
    task automatic send_triangle(logic [9:0][31:0] t);
        int g;
        start  <= 1'b1;
        tri_in <= t;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            default:
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'hffff_ffff;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    task automatic set_plane(int kind);
        logic [31:0] v [NUM_REGS];
        for (int i = 0; i < NUM_REGS; i++)
            v[i] = coord(kind == 1 ? 1 : (kind == 2 ? 2 : 0));
        if (kind == 3)
        begin
            v[REG_NORMAL_X] = 32'd0;
            v[REG_NORMAL_Y] = 32'd0;
            v[REG_NORMAL_Z] = 32'd0;
        end
        if (kind == 4)
        begin
            v[REG_POINT_X] = 32'h8000_0000;
            v[REG_POINT_Y] = 32'h7fff_ffff;
            v[REG_NORMAL_X] = 32'h8000_0000;
            v[REG_NORMAL_Y] = 32'h7fff_ffff;
            v[REG_NORMAL_Z] = 32'h8000_0000;
        end
        for (int i = 0; i < NUM_REGS; i++)
            reg_write(3'(i), v[i]);
    endtask

    initial
    begin
        logic [9:0][31:0] t;
        logic [31:0] zin;
        logic [31:0] zout;
        int mode;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default plane z = 0.1, inward normal +z; every inside pattern
        for (int m = 0; m < 8; m++)
            for (int v = 0; v < 2; v++)
            begin
                zin  = v ? 32'h7fff_ffff : 32'd6554;
                zout = v ? 32'h8000_0000 : 32'd6553;
                for (int k = 0; k < 3; k++)
                begin
                    t[3*k]   = v ? (k[0] ? 32'h8000_0000 : 32'h7fff_ffff) : coord(1);
                    t[3*k+1] = v ? (k[0] ? 32'h7fff_ffff : 32'h8000_0000) : coord(1);
                    t[3*k+2] = m[k] ? zin : zout;
                end
                t[9] = v ? 32'hffff_ffff : 32'd0;
                send_triangle(t);
            end
        drain();

        // writes past the last register are ignored
        reg_write(3'd6, 32'h1234_5678);
        reg_write(3'd7, 32'h8765_4321);

        for (int phase = 0; phase < 8; phase++)
        begin
            set_plane(phase % 5);
            for (int n = 0; n < 200; n++)
            begin
                mode = $urandom_range(2);
                for (int i = 0; i < 9; i++)
                    t[i] = coord(mode);
                t[9] = $urandom;
                send_triangle(t);
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
